// ===== hw/rtl/retrigger_arpeggio_scheduler_defines.svh =====
// assertion macros shared by the retrigger arpeggio scheduler checkers
// expects signals named clk and arst_n in the scope of each use
`ifndef RETRIGGER_ARPEGGIO_SCHEDULER_DEFINES_SVH
`define RETRIGGER_ARPEGGIO_SCHEDULER_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define RTARP_ASSERT_NOW(label, trig, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (expr)) \
		else $error("rtarp same-cycle check failed");

// condition must hold in the cycle after the trigger
`define RTARP_ASSERT_NEXT(label, trig, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) \
		else $error("rtarp next-cycle check failed");

`endif

// ===== hw/rtl/rtarp_pkg.sv =====
// shared types and constants of the retrigger arpeggio scheduler
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package rtarp_pkg;

	// arpeggio step count and derived widths
	localparam int unsigned ARP_STEPS = 3;
	localparam int unsigned ARP_SLOTS = 3;
	localparam int unsigned LEN_W = $clog2(ARP_STEPS + 1);
	localparam int unsigned LEN_ARP2 = (ARP_STEPS < 2) ? ARP_STEPS : 2;
	localparam int unsigned LEN_ARP3 = (ARP_STEPS < 3) ? ARP_STEPS : 3;
	localparam int unsigned IDX_ARP2 = (LEN_ARP2 > 1) ? 1 : 0;
	localparam int unsigned IDX_ARP3 = (LEN_ARP3 > 1) ? 1 : 0;

	// command queue between front and back
	localparam int unsigned MID_DEPTH = 4;

	// timing widths
	localparam int unsigned SPT_W = 16;
	localparam int unsigned POS_W = 17;

	localparam logic [SPT_W-1:0] SPT_RESET = 16'd2205;

	// action codes
	localparam logic [1:0] ACT_NOTE_ON = 2'd0;
	localparam logic [1:0] ACT_EFFECT  = 2'd1;
	localparam logic [1:0] ACT_ADVANCE = 2'd2;

	// effect codes, column a
	localparam logic [7:0] FX_RETRIG      = 8'hED;
	localparam logic [7:0] FX_REWIND      = 8'hFD;
	// effect codes, column b
	localparam logic [7:0] FX_ARP3        = 8'h05;
	localparam logic [7:0] FX_ARP2        = 8'h06;
	localparam logic [7:0] FX_RETRIG_FINE = 8'hE9;

	// offset that suppresses a trigger
	localparam logic [7:0] OFF_SKIP = 8'h80;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_NOTE_ON,
		CMD_REWIND,
		CMD_PROGRAM,
		CMD_ADVANCE
	} cmd_kind_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  note_code;
		logic [7:0]  accent;
		logic [7:0]  note_length;
		logic        second_column;
		logic [7:0]  effect_code;
		logic [15:0] effect_value;
		logic [15:0] max_samples;
	} rtarp_item_t;

	typedef struct packed {
		logic [15:0] granted_samples;
		logic        trigger;
		logic [7:0]  trigger_note;
		logic [7:0]  trigger_accent;
		logic [7:0]  trigger_length;
	} rtarp_result_t;

	// classified command, as the back end executes it
	typedef struct packed {
		cmd_kind_t        kind;
		logic [POS_W-1:0] period;
		logic [POS_W-1:0] position;
		logic             wr_off1;
		logic             wr_off2;
		logic [7:0]       off1;
		logic [7:0]       off2;
		logic [LEN_W-1:0] arp_index;
		logic [LEN_W-1:0] arp_length;
		logic [7:0]       note;
		logic [7:0]       accent;
		logic [7:0]       length;
		logic [15:0]      max_samples;
	} rtarp_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rtarp_fifo.sv =====
// command queue between the front and back ends
// depends on rtarp_pkg for the command type and depth
`timescale 1ns / 1ps
`default_nettype none

module rtarp_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  rtarp_pkg::rtarp_cmd_t   din,
	input  wire logic               pop,
	output logic                    empty,
	output rtarp_pkg::rtarp_cmd_t   dout
);
	import rtarp_pkg::*;

	localparam int unsigned PTR_W = $clog2(MID_DEPTH);
	localparam int unsigned CNT_W = $clog2(MID_DEPTH + 1);

	rtarp_cmd_t       mem_q [MID_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(MID_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// storage, no reset
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(MID_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(MID_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rtarp_front.sv =====
// front end: holds samples_per_tick, classifies items and works out
// period and start position (multiply, then divide by twelve); uses rtarp_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtarp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_write,
	input  wire logic [15:0]       cfg_data,
	input  wire logic              push,
	output logic                   full,
	input  rtarp_pkg::rtarp_item_t item,
	output logic                   cmd_push,
	input  wire logic              cmd_full,
	output rtarp_pkg::rtarp_cmd_t  cmd
);
	import rtarp_pkg::*;

	localparam int unsigned PP_W  = 20;
	localparam int unsigned Y_W   = PP_W - 2;
	localparam int unsigned RP_W  = 36;
	localparam int unsigned RECIP_SHIFT = 19;
	localparam logic [3:0]  TICK_DIV   = 4'd12;
	localparam logic [3:0]  THIRD_MUL  = 4'd4;
	localparam logic [PP_W-1:0] ROUND_UP = PP_W'(TICK_DIV - 4'd1);
	// ceil(2^19 / 3): exact quotient for any 18-bit dividend
	localparam logic [Y_W-1:0] RECIP3 = 18'd174763;

	logic [SPT_W-1:0] spt_q;

	// decode outputs
	rtarp_cmd_t       cmd_c;
	logic [3:0]       mul_p_c;
	logic             plus_one_c;
	logic             round_p_c;
	logic             inc_p_c;
	logic [3:0]       mul_q_c;
	logic             round_q_c;
	logic [POS_W-1:0] op_p_c;
	logic [PP_W-1:0]  prod_p_c;
	logic [PP_W-1:0]  prod_q_c;
	logic [3:0]       nib_lo;
	logic [3:0]       nib_hi;
	logic [7:0]       byte_hi;
	logic [7:0]       byte_lo;

	// stage 1
	logic             valid_s1;
	rtarp_cmd_t       cmd_s1;
	logic [PP_W-1:0]  pp_s1;
	logic [PP_W-1:0]  pq_s1;
	logic             round_p_s1;
	logic             round_q_s1;
	logic             inc_s1;

	// stage 2
	logic             valid_s2;
	rtarp_cmd_t       cmd_s2;
	logic [RP_W-1:0]  rp_s2;
	logic [RP_W-1:0]  rq_s2;
	logic             inc_s2;

	logic [PP_W-1:0]  xp_c;
	logic [PP_W-1:0]  xq_c;
	logic [RP_W-1:0]  rp_c;
	logic [RP_W-1:0]  rq_c;
	logic             adv;

	assign nib_lo  = item.effect_value[3:0];
	assign nib_hi  = item.effect_value[7:4];
	assign byte_hi = item.effect_value[15:8];
	assign byte_lo = item.effect_value[7:0];

	// tick length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spt_q <= SPT_RESET;
		end else if (cfg_write) begin
			spt_q <= cfg_data;
		end
	end

	// classify the item and choose multiplier operands
	always_comb begin
		cmd_c             = '0;
		cmd_c.kind        = CMD_NONE;
		cmd_c.note        = item.note_code;
		cmd_c.accent      = item.accent;
		cmd_c.length      = item.note_length;
		cmd_c.max_samples = item.max_samples;
		cmd_c.arp_length  = LEN_W'(1);
		cmd_c.arp_index   = '0;
		mul_p_c           = '0;
		plus_one_c        = 1'b0;
		round_p_c         = 1'b0;
		inc_p_c           = 1'b0;
		mul_q_c           = '0;
		round_q_c         = 1'b0;
		case (item.action)
			ACT_NOTE_ON: begin
				cmd_c.kind = CMD_NOTE_ON;
			end
			ACT_ADVANCE: begin
				cmd_c.kind = CMD_ADVANCE;
			end
			ACT_EFFECT: begin
				if (!item.second_column) begin
					case (item.effect_code)
						FX_RETRIG: begin
							// spt - n*spt/12 == ceil((12-n)*spt/12)
							cmd_c.kind = CMD_PROGRAM;
							mul_p_c    = TICK_DIV;
							mul_q_c    = (nib_lo > TICK_DIV) ? 4'd0 : TICK_DIV - nib_lo;
							round_q_c  = 1'b1;
						end
						FX_REWIND: begin
							cmd_c.kind = CMD_REWIND;
						end
						default: begin
							cmd_c.kind = CMD_NONE;
						end
					endcase
				end else begin
					case (item.effect_code)
						FX_ARP3: begin
							cmd_c.kind       = CMD_PROGRAM;
							cmd_c.wr_off1    = 1'b1;
							cmd_c.wr_off2    = 1'b1;
							cmd_c.off1       = byte_hi;
							cmd_c.off2       = byte_lo;
							cmd_c.arp_index  = LEN_W'(IDX_ARP3);
							cmd_c.arp_length = LEN_W'(LEN_ARP3);
							mul_p_c          = THIRD_MUL;
							inc_p_c          = 1'b1;
						end
						FX_ARP2: begin
							cmd_c.kind       = CMD_PROGRAM;
							cmd_c.wr_off1    = 1'b1;
							cmd_c.off1       = byte_lo;
							cmd_c.arp_index  = LEN_W'(IDX_ARP2);
							cmd_c.arp_length = LEN_W'(LEN_ARP2);
							mul_p_c          = TICK_DIV;
							plus_one_c       = 1'b1;
							mul_q_c          = (byte_hi > 8'(TICK_DIV)) ? 4'd0
								: 4'(8'(TICK_DIV) - byte_hi);
						end
						FX_RETRIG_FINE: begin
							cmd_c.kind = CMD_PROGRAM;
							mul_p_c    = nib_lo;
							plus_one_c = 1'b1;
							round_p_c  = 1'b1;
							mul_q_c    = nib_hi;
						end
						default: begin
							cmd_c.kind = CMD_NONE;
						end
					endcase
				end
			end
			default: begin
				cmd_c.kind = CMD_NONE;
			end
		endcase
	end

	// products of stage 1, both below 2^20
	assign op_p_c   = plus_one_c ? {1'b0, spt_q} + POS_W'(1) : {1'b0, spt_q};
	assign prod_p_c = PP_W'(mul_p_c) * PP_W'(op_p_c);
	assign prod_q_c = PP_W'(mul_q_c) * PP_W'(spt_q);

	// divide by twelve: drop two bits, then multiply by the reciprocal of three
	assign xp_c = pp_s1 + (round_p_s1 ? ROUND_UP : '0);
	assign xq_c = pq_s1 + (round_q_s1 ? ROUND_UP : '0);
	assign rp_c = {{(RP_W - Y_W){1'b0}}, xp_c[PP_W-1:2]} * {{(RP_W - Y_W){1'b0}}, RECIP3};
	assign rq_c = {{(RP_W - Y_W){1'b0}}, xq_c[PP_W-1:2]} * {{(RP_W - Y_W){1'b0}}, RECIP3};

	// pipeline moves as one unless the queue refuses stage 2
	assign adv      = !valid_s2 || !cmd_full;
	assign full     = !adv;
	assign cmd_push = valid_s2 && !cmd_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= push;
			valid_s2 <= valid_s1;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1     <= cmd_c;
			pp_s1      <= prod_p_c;
			pq_s1      <= prod_q_c;
			round_p_s1 <= round_p_c;
			round_q_s1 <= round_q_c;
			inc_s1     <= inc_p_c;
			cmd_s2     <= cmd_s1;
			rp_s2      <= rp_c;
			rq_s2      <= rq_c;
			inc_s2     <= inc_s1;
		end
	end

	// finished command
	always_comb begin
		cmd          = cmd_s2;
		cmd.period   = rp_s2[RECIP_SHIFT +: POS_W] + POS_W'(inc_s2);
		cmd.position = rq_s2[RECIP_SHIFT +: POS_W];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rtarp_back.sv =====
// back end: retrigger state, sample grants, trigger note and result queue
// depends on rtarp_pkg for command and result types
`timescale 1ns / 1ps
`default_nettype none

module rtarp_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_empty,
	output logic                     cmd_pop,
	input  rtarp_pkg::rtarp_cmd_t    cmd,
	input  wire logic                pop,
	output logic                     empty,
	output rtarp_pkg::rtarp_result_t result
);
	import rtarp_pkg::*;

	localparam logic [8:0] NOTES_PER_OCT = 9'd12;
	localparam logic [8:0] SEQ_BIAS      = 9'd128;
	localparam logic [8:0] SEQ_TOP       = 9'd247;
	localparam logic [6:0] SEQ_MAX       = 7'd119;
	localparam logic [3:0] SEMI_MAX      = 4'd12;
	// floor(seq * 43 / 512) == seq / 12 for seq up to 119
	localparam logic [12:0] OCT_RECIP    = 13'd43;
	localparam int unsigned OCT_SHIFT    = 9;

	// sequential note number with octave wrap and clamping
	function automatic logic [7:0] shift_note(input logic [7:0] note, input logic [7:0] off);
		logic [3:0]  semi;
		logic [8:0]  sb;
		logic [6:0]  clip;
		logic [12:0] qm;
		logic [3:0]  oct;
		logic [6:0]  rem;
		semi = note[3:0];
		if (semi == 4'd0) begin
			semi = 4'd1;
		end else if (semi > SEMI_MAX) begin
			semi = SEMI_MAX;
		end
		// biased by 128 so the signed offset stays unsigned
		sb = 9'(note[7:4]) * NOTES_PER_OCT + 9'(semi) - 9'd1 + 9'(off ^ OFF_SKIP);
		if (sb < SEQ_BIAS) begin
			clip = 7'd0;
		end else if (sb > SEQ_TOP) begin
			clip = SEQ_MAX;
		end else begin
			clip = 7'(sb - SEQ_BIAS);
		end
		qm  = 13'(clip) * OCT_RECIP;
		oct = qm[OCT_SHIFT +: 4];
		rem = clip - 7'(oct) * 7'(NOTES_PER_OCT);
		return {oct, 4'(rem + 7'd1)};
	endfunction

	// retrigger state
	logic [POS_W-1:0] period_q;
	logic [POS_W-1:0] position_q;
	logic [7:0]       offs_q [ARP_SLOTS];
	logic [LEN_W-1:0] arp_index_q;
	logic [LEN_W-1:0] arp_length_q;
	logic [7:0]       base_note_q;
	logic [7:0]       held_accent_q;
	logic [7:0]       held_length_q;

	// execute stage
	logic             valid_s3;
	logic [15:0]      granted_s3;
	logic             trig_s3;
	logic [7:0]       base_s3;
	logic [7:0]       off_s3;
	logic [7:0]       acc_s3;
	logic [7:0]       len_s3;

	// result queue
	rtarp_result_t    out_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       out_cnt_q;

	logic             out_full;
	logic             out_push;
	logic             out_pop;
	logic             take;
	logic [POS_W-1:0] diff_c;
	logic [15:0]      grant_c;
	logic [POS_W:0]   sum_c;
	logic             wrap_c;
	logic [7:0]       off_c;
	logic             live_c;
	logic [LEN_W:0]   idx_inc_c;
	logic [LEN_W-1:0] idx_next_c;
	logic             trig_c;
	logic [15:0]      granted_c;
	rtarp_result_t    res_c;

	// handshakes
	assign out_full = (out_cnt_q == 2'd2);
	assign empty    = (out_cnt_q == 2'd0);
	assign out_push = valid_s3 && !out_full;
	assign out_pop  = pop && !empty;
	assign take     = !cmd_empty && (!valid_s3 || out_push);
	assign cmd_pop  = take;

	// advance arithmetic
	assign live_c  = (period_q != '0);
	assign diff_c  = (position_q >= period_q) ? '0 : period_q - position_q;
	assign grant_c = (diff_c < {1'b0, cmd.max_samples}) ? diff_c[15:0] : cmd.max_samples;
	assign sum_c   = {1'b0, position_q} + (POS_W + 1)'(grant_c);
	assign wrap_c  = (sum_c >= {1'b0, period_q});
	assign off_c   = (arp_index_q < LEN_W'(ARP_SLOTS)) ? offs_q[arp_index_q] : 8'd0;

	assign idx_inc_c  = {1'b0, arp_index_q} + 1'b1;
	assign idx_next_c = (idx_inc_c >= {1'b0, arp_length_q}) ? '0 : idx_inc_c[LEN_W-1:0];

	assign trig_c    = (cmd.kind == CMD_ADVANCE) && live_c && wrap_c && (off_c != OFF_SKIP);
	assign granted_c = (cmd.kind != CMD_ADVANCE) ? 16'd0 : (live_c ? grant_c : cmd.max_samples);

	// state update per command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q      <= '0;
			position_q    <= '0;
			offs_q[0]     <= '0;
			offs_q[1]     <= '0;
			offs_q[2]     <= '0;
			arp_index_q   <= '0;
			arp_length_q  <= LEN_W'(1);
			base_note_q   <= 8'd1;
			held_accent_q <= '0;
			held_length_q <= '0;
		end else if (take) begin
			case (cmd.kind)
				CMD_NOTE_ON: begin
					base_note_q   <= cmd.note;
					held_accent_q <= cmd.accent;
					held_length_q <= cmd.length;
					position_q    <= '0;
				end
				CMD_REWIND: begin
					position_q <= '0;
				end
				CMD_PROGRAM: begin
					period_q     <= cmd.period;
					position_q   <= cmd.position;
					offs_q[0]    <= '0;
					arp_index_q  <= cmd.arp_index;
					arp_length_q <= cmd.arp_length;
					if (cmd.wr_off1) begin
						offs_q[1] <= cmd.off1;
					end
					if (cmd.wr_off2) begin
						offs_q[2] <= cmd.off2;
					end
				end
				CMD_ADVANCE: begin
					if (live_c) begin
						if (wrap_c) begin
							position_q  <= '0;
							arp_index_q <= idx_next_c;
						end else begin
							position_q <= sum_c[POS_W-1:0];
						end
					end
				end
				default: begin
					period_q <= period_q;
				end
			endcase
		end
	end

	// execute stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (take) begin
			valid_s3 <= 1'b1;
		end else if (out_push) begin
			valid_s3 <= 1'b0;
		end
	end

	// execute stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			granted_s3 <= granted_c;
			trig_s3    <= trig_c;
			base_s3    <= base_note_q;
			off_s3     <= off_c;
			acc_s3     <= trig_c ? held_accent_q : 8'd0;
			len_s3     <= trig_c ? held_length_q : 8'd0;
		end
	end

	// finish the trigger note
	always_comb begin
		res_c.granted_samples = granted_s3;
		res_c.trigger         = trig_s3;
		res_c.trigger_note    = trig_s3 ? shift_note(base_s3, off_s3) : 8'd0;
		res_c.trigger_accent  = acc_s3;
		res_c.trigger_length  = len_s3;
	end

	// two-entry result queue
	always_ff @(posedge clk) begin
		if (out_push) begin
			out_q[wr_ptr_q] <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= 1'b0;
			rd_ptr_q  <= 1'b0;
			out_cnt_q <= 2'd0;
		end else begin
			if (out_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (out_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (out_push && !out_pop) begin
				out_cnt_q <= out_cnt_q + 2'd1;
			end else if (out_pop && !out_push) begin
				out_cnt_q <= out_cnt_q - 2'd1;
			end
		end
	end

	assign result = out_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== hw/rtl/retrigger_arpeggio_scheduler.sv =====
// Retrigger and arpeggio scheduler for one tracker track, in sample time.
// Input channel: present an item with push; it is taken at a clock edge where
// push is high and full is low. Note-on, effect and advance items all give
// exactly one result item each.
// Result channel: while empty is low the oldest result sits on result; it is
// taken at an edge where pop is high. Results leave in input order.
// Config: cfg_write with cfg_data loads samples_per_tick (reset 2205); write
// it only while no item is in flight.
// Path: an item passes the two front stages for the multiply and divide by
// twelve, the command queue, the execute stage of the back end and the
// two-entry result queue before its result is visible on result.
// Throughput: one item per cycle when pop is held high; the back end updates
// the retrigger state once per command taken, which sets that rate.
// Stall: up to nine items are buffered; when pop is held low the result
// queue fills, then the command queue, and full rises.
// Reset (arst_n low): all queues empty, retrigger disabled, base note 1.
// depends on rtarp_pkg, rtarp_front, rtarp_fifo and rtarp_back
`timescale 1ns / 1ps
`default_nettype none

module retrigger_arpeggio_scheduler (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_write,
	input  wire logic [15:0]         cfg_data,
	input  wire logic                push,
	output logic                     full,
	input  rtarp_pkg::rtarp_item_t   item,
	output logic                     empty,
	input  wire logic                pop,
	output rtarp_pkg::rtarp_result_t result
);
	import rtarp_pkg::*;

	logic       mid_push;
	logic       mid_full;
	logic       mid_pop;
	logic       mid_empty;
	rtarp_cmd_t mid_in;
	rtarp_cmd_t mid_out;

	// classify and precompute
	rtarp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_data (cfg_data),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd_push (mid_push),
		.cmd_full (mid_full),
		.cmd      (mid_in)
	);

	// decoupling queue
	rtarp_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.full  (mid_full),
		.din   (mid_in),
		.pop   (mid_pop),
		.empty (mid_empty),
		.dout  (mid_out)
	);

	// execute and buffer results
	rtarp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(mid_empty),
		.cmd_pop  (mid_pop),
		.cmd      (mid_out),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/rtarp_checker.sv =====
// port-level checks on the scheduler result channel, bound to the top level
// depends on rtarp_pkg and retrigger_arpeggio_scheduler_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "retrigger_arpeggio_scheduler_defines.svh"

module rtarp_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                empty,
	input wire logic                pop,
	input rtarp_pkg::rtarp_result_t result
);
	import rtarp_pkg::*;

	// no trigger means the note fields are all cleared
	`RTARP_ASSERT_NOW(a_quiet_fields_zero, !empty && !result.trigger, result.trigger_note == 8'd0 && result.trigger_accent == 8'd0 && result.trigger_length == 8'd0)

	// a triggered note is always a legal note code
	`RTARP_ASSERT_NOW(a_trigger_note_legal, !empty && result.trigger, result.trigger_note[3:0] != 4'd0 && result.trigger_note[3:0] <= 4'd12 && result.trigger_note <= 8'h9C)

	// a waiting result holds until taken
	`RTARP_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(result))

endmodule

bind retrigger_arpeggio_scheduler rtarp_checker u_rtarp_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking testbench of retrigger_arpeggio_scheduler: directed table, then random phases
// holds its own scheduler predictor; depends on rtarp_pkg and the scheduler rtl
`timescale 1ns / 1ps

module tb_top;
	import rtarp_pkg::*;

	// action that the block ignores, effect code that no column knows
	localparam logic [1:0] ACT_IDLE = 2'd3;
	localparam logic [7:0] FX_NONE = 8'h00;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned PHASE_ITEMS = 106;
	localparam int unsigned PRINT_CAP = 100;

	typedef struct {
		rtarp_item_t   it;
		logic          known;
		rtarp_result_t want;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [15:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	rtarp_item_t item = '0;
	logic empty;
	logic pop = 1'b0;
	rtarp_result_t result;

	// row side band: typed expectation of a directed item
	logic row_known = 1'b0;
	rtarp_result_t row_want = '0;

	stim_t stim_q[$];
	rtarp_result_t due_results[$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	// predictor copy of the scheduler state and the tick register
	logic [15:0] tick_len = SPT_RESET;
	int unsigned rt_period = 0;
	int unsigned rt_pos = 0;
	logic [7:0] arp_off [3] = '{default: 8'h00};
	int unsigned arp_idx = 0;
	int unsigned arp_len = 1;
	logic [7:0] note_base = 8'h01;
	logic [7:0] acc_hold = 8'h00;
	logic [7:0] len_hold = 8'h00;

	retrigger_arpeggio_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	// clock, 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// base note moved by a signed semitone offset, clamped to the note range
	function automatic logic [7:0] arp_note(input logic [7:0] note, input logic [7:0] off);
		int semi;
		int oct;
		int seq;
		semi = int'(note[3:0]);
		oct = int'(note[7:4]);
		if (semi < 1) semi = 1;
		if (semi > 12) semi = 12;
		seq = oct * 12 + semi - 1 + int'($signed(off));
		if (seq < 0) seq = 0;
		if (seq > 119) seq = 119;
		return 8'((seq / 12) * 16 + seq % 12 + 1);
	endfunction

	// one item through the scheduler: updates state, returns the result item
	function automatic rtarp_result_t schedule_item(input rtarp_item_t it);
		rtarp_result_t r;
		int unsigned spt;
		int unsigned v;
		int unsigned sub;
		int unsigned hi;
		int unsigned diff;
		int unsigned grant;
		int unsigned lenc;
		int unsigned slot;
		r = '0;
		grant = 0;
		spt = tick_len;
		v = it.effect_value;
		case (it.action)
			ACT_NOTE_ON: begin
				note_base = it.note_code;
				acc_hold = it.accent;
				len_hold = it.note_length;
				rt_pos = 0;
			end
			ACT_EFFECT: begin
				if (!it.second_column) begin
					if (it.effect_code == FX_RETRIG) begin
						sub = (v & 15) * spt / 12;
						rt_period = spt;
						rt_pos = (sub > spt) ? 0 : spt - sub;
						arp_off[0] = 8'h00;
						arp_idx = 0;
						arp_len = 1;
					end else if (it.effect_code == FX_REWIND) begin
						rt_pos = 0;
					end
				end else if (it.effect_code == FX_ARP3) begin
					rt_period = spt / 3 + 1;
					rt_pos = 0;
					arp_off[0] = 8'h00;
					arp_off[1] = it.effect_value[15:8];
					arp_off[2] = it.effect_value[7:0];
					arp_idx = 1;
					arp_len = (ARP_STEPS < 3) ? ARP_STEPS : 3;
				end else if (it.effect_code == FX_ARP2) begin
					hi = v >> 8;
					rt_period = spt + 1;
					rt_pos = (hi > 12) ? 0 : (12 - hi) * spt / 12;
					arp_off[0] = 8'h00;
					arp_off[1] = it.effect_value[7:0];
					arp_idx = 1;
					arp_len = (ARP_STEPS < 2) ? ARP_STEPS : 2;
				end else if (it.effect_code == FX_RETRIG_FINE) begin
					rt_period = ((v & 15) * (spt + 1) + 11) / 12;
					rt_pos = ((v >> 4) & 15) * spt / 12;
					arp_off[0] = 8'h00;
					arp_idx = 0;
					arp_len = 1;
				end
			end
			ACT_ADVANCE: begin
				if (rt_period != 0) begin
					diff = (rt_pos >= rt_period) ? 0 : rt_period - rt_pos;
					grant = (diff < it.max_samples) ? diff : it.max_samples;
					rt_pos += grant;
					// period reached: rewind and fire the current arpeggio step
					if (rt_pos >= rt_period) begin
						lenc = (arp_len == 0) ? 1 : arp_len;
						slot = (arp_idx % lenc) % 3;
						rt_pos = 0;
						if (arp_off[slot] != OFF_SKIP) begin
							r.trigger = 1'b1;
							r.trigger_note = arp_note(note_base, arp_off[slot]);
							r.trigger_accent = acc_hold;
							r.trigger_length = len_hold;
						end
						arp_idx = ((arp_idx % lenc) + 1) % lenc;
					end
				end else begin
					grant = it.max_samples;
				end
			end
			default: ;
		endcase
		r.granted_samples = 16'(grant);
		return r;
	endfunction

	task automatic flag(input string what, input int unsigned got, input int unsigned want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t: %s is %0h, %0h was due", $time, what, got, want);
	endtask

	// scoreboard: check results against the oldest due one, predict on accepted items
	always @(posedge clk) begin : scoreboard
		rtarp_result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (due_results.size() == 0) begin
					flag("result with nothing due", result, 0);
				end else begin
					want = due_results.pop_front();
					if (result.granted_samples != want.granted_samples)
						flag("granted_samples", result.granted_samples, want.granted_samples);
					if (result.trigger != want.trigger)
						flag("trigger", result.trigger, want.trigger);
					if (result.trigger_note != want.trigger_note)
						flag("trigger_note", result.trigger_note, want.trigger_note);
					if (result.trigger_accent != want.trigger_accent)
						flag("trigger_accent", result.trigger_accent, want.trigger_accent);
					if (result.trigger_length != want.trigger_length)
						flag("trigger_length", result.trigger_length, want.trigger_length);
				end
			end
			if (push && !full) begin
				want = schedule_item(item);
				if (row_known)
					want = row_want;
				due_results.push_back(want);
			end
		end
	end

	// result side: stalls in stretches of changing pattern
	initial begin : pop_pattern
		int mode;
		int span;
		forever begin
			mode = $urandom_range(0, 4);
			span = $urandom_range(4, 60);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0: pop <= 1'b1;
					1: pop <= ($urandom_range(0, 3) == 0);
					2: pop <= ~pop;
					3: pop <= 1'b0;
					default: pop <= $urandom_range(0, 1);
				endcase
			end
		end
	end

	function automatic rtarp_item_t mk_item(input logic [1:0] action, input logic [7:0] note,
			input logic [7:0] acc, input logic [7:0] len, input logic col,
			input logic [7:0] code, input logic [15:0] val, input logic [15:0] maxs);
		rtarp_item_t it;
		it.action = action;
		it.note_code = note;
		it.accent = acc;
		it.note_length = len;
		it.second_column = col;
		it.effect_code = code;
		it.effect_value = val;
		it.max_samples = maxs;
		return it;
	endfunction

	function automatic rtarp_item_t rand_item();
		rtarp_item_t it;
		it.action = 2'($urandom_range(0, 3));
		it.note_code = 8'($urandom);
		it.accent = 8'($urandom);
		it.note_length = 8'($urandom);
		it.second_column = 1'($urandom);
		it.effect_code = 8'($urandom);
		it.effect_value = 16'($urandom);
		it.max_samples = 16'($urandom);
		return it;
	endfunction

	// semitone offset: any byte, a musical interval, the skip mark or a small value
	function automatic logic [7:0] rand_offset();
		case ($urandom_range(0, 3))
			0: return 8'($urandom);
			1: return 8'($urandom_range(0, 48) - 24);
			2: return OFF_SKIP;
			default: return 8'($urandom_range(0, 15));
		endcase
	endfunction

	function automatic rtarp_item_t rand_advance();
		rtarp_item_t it;
		it = rand_item();
		it.action = ACT_ADVANCE;
		case ($urandom_range(0, 5))
			0: it.max_samples = 16'($urandom_range(0, 16));
			1: it.max_samples = 16'($urandom);
			2: it.max_samples = 16'hFFFF;
			3: it.max_samples = 16'h0000;
			default: it.max_samples = 16'($urandom_range(0, tick_len / 2 + 1));
		endcase
		return it;
	endfunction

	task automatic queue_item(input rtarp_item_t it, input logic known, input rtarp_result_t want);
		stim_t s;
		s.it = it;
		s.known = known;
		s.want = want;
		stim_q.push_back(s);
	endtask

	// random phase: mostly note, program, advances; some noise and broken commands
	task automatic build_phase(input int unsigned n);
		rtarp_item_t it;
		int k;
		while (stim_q.size() < n) begin
			if ($urandom_range(0, 9) < 8) begin
				if ($urandom_range(0, 2) != 0) begin
					it = rand_item();
					it.action = ACT_NOTE_ON;
					queue_item(it, 1'b0, '0);
				end
				it = rand_item();
				it.action = ACT_EFFECT;
				case ($urandom_range(0, 4))
					0: begin
						it.second_column = 1'b0;
						it.effect_code = FX_RETRIG;
					end
					1: begin
						it.second_column = 1'b0;
						it.effect_code = FX_REWIND;
					end
					2: begin
						it.second_column = 1'b1;
						it.effect_code = FX_ARP3;
						it.effect_value = {rand_offset(), rand_offset()};
					end
					3: begin
						it.second_column = 1'b1;
						it.effect_code = FX_ARP2;
						it.effect_value = {rand_offset(), rand_offset()};
					end
					default: begin
						it.second_column = 1'b1;
						it.effect_code = FX_RETRIG_FINE;
					end
				endcase
				queue_item(it, 1'b0, '0);
				k = $urandom_range(1, 10);
				repeat (k) queue_item(rand_advance(), 1'b0, '0);
			end else begin
				it = rand_item();
				// known code in a random column: often the wrong one
				if ($urandom_range(0, 1) != 0) begin
					case ($urandom_range(0, 4))
						0: it.effect_code = FX_RETRIG;
						1: it.effect_code = FX_REWIND;
						2: it.effect_code = FX_ARP3;
						3: it.effect_code = FX_ARP2;
						default: it.effect_code = FX_RETRIG_FINE;
					endcase
				end
				queue_item(it, 1'b0, '0);
			end
		end
	endtask

	// sender: bursts of random length, random gaps, sometimes none
	task automatic play_queue();
		int burst;
		stim_t s;
		while (stim_q.size() != 0) begin
			burst = $urandom_range(1, 24);
			while (burst != 0 && stim_q.size() != 0) begin
				s = stim_q.pop_front();
				push <= 1'b1;
				item <= s.it;
				row_known <= s.known;
				row_want <= s.want;
				@(posedge clk);
				while (full) @(posedge clk);
				burst--;
			end
			if ($urandom_range(0, 3) != 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		push <= 1'b0;
	endtask

	// block idle: the last accepted item is on the due list, then nothing is due
	task automatic wait_drain();
		@(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_tick(input logic [15:0] v);
		wait_drain();
		cfg_write <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		tick_len = v;
	endtask

	initial begin : stimulus
		int unsigned tick_plan [8];
		tick_plan = '{1, 65535, 12, 3, 0, 0, 2, 2205};
		tick_plan[4] = $urandom_range(4, 64);
		tick_plan[5] = $urandom_range(1, 65535);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset tick length
		// disabled retrigger grants everything
		queue_item(mk_item(ACT_ADVANCE, 8'h00, 8'h00, 8'h00, 1'b0, FX_NONE, 16'h0000, 16'hFFFF),
			1'b1, {16'hFFFF, 25'd0});
		queue_item(mk_item(ACT_ADVANCE, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 16'hFFFF, 16'h0000),
			1'b1, '0);
		queue_item(mk_item(ACT_IDLE, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF),
			1'b1, '0);
		queue_item(mk_item(ACT_NOTE_ON, 8'h9C, 8'hF0, 8'hF0, 1'b0, FX_NONE, 16'h0000, 16'h0000),
			1'b1, '0);
		// unknown code and codes in the wrong column do nothing
		queue_item(mk_item(ACT_EFFECT, 8'h00, 8'h00, 8'h00, 1'b0, FX_NONE, 16'hFFFF, 16'h0000),
			1'b1, '0);
		queue_item(mk_item(ACT_EFFECT, 8'h00, 8'h00, 8'h00, 1'b0, FX_ARP3, 16'h0C0C, 16'h0000),
			1'b1, '0);
		queue_item(mk_item(ACT_EFFECT, 8'h00, 8'h00, 8'h00, 1'b1, FX_RETRIG, 16'h0003, 16'h0000),
			1'b1, '0);
		// retrigger with n above twelve: start position saturates at zero
		queue_item(mk_item(ACT_EFFECT, 8'h00, 8'h00, 8'h00, 1'b0, FX_RETRIG, 16'h000F, 16'h0000),
			1'b1, '0);
		queue_item(mk_item(ACT_ADVANCE, 8'h00, 8'h00, 8'h00, 1'b0, FX_NONE, 16'h0000, 16'hFFFF),
			1'b0, '0);
		queue_item(mk_item(ACT_EFFECT, 8'h00, 8'h00, 8'h00, 1'b0, FX_RETRIG, 16'h0006, 16'h0000),
			1'b1, '0);
		queue_item(mk_item(ACT_ADVANCE, 8'h00, 8'h00, 8'h00, 1'b0, FX_NONE, 16'h0000, 16'd100),
			1'b0, '0);
		queue_item(mk_item(ACT_ADVANCE, 8'h00, 8'h00, 8'h00, 1'b0, FX_NONE, 16'h0000, 16'hFFFF),
			1'b0, '0);
		// two-step arpeggio, high byte above twelve, skip mark on the second step
		queue_item(mk_item(ACT_EFFECT, 8'h00, 8'h00, 8'h00, 1'b1, FX_ARP2, 16'h0D80, 16'h0000),
			1'b1, '0);
		queue_item(mk_item(ACT_ADVANCE, 8'h00, 8'h00, 8'h00, 1'b0, FX_NONE, 16'h0000, 16'hFFFF),
			1'b0, '0);
		queue_item(mk_item(ACT_ADVANCE, 8'h00, 8'h00, 8'h00, 1'b0, FX_NONE, 16'h0000, 16'hFFFF),
			1'b0, '0);
		// three-step arpeggio from the lowest note: skip, then clamp at note 1
		queue_item(mk_item(ACT_NOTE_ON, 8'h01, 8'h00, 8'h00, 1'b0, FX_NONE, 16'h0000, 16'h0000),
			1'b1, '0);
		queue_item(mk_item(ACT_EFFECT, 8'h00, 8'h00, 8'h00, 1'b1, FX_ARP3, 16'h80F4, 16'h0000),
			1'b1, '0);
		repeat (3)
			queue_item(mk_item(ACT_ADVANCE, 8'h00, 8'h00, 8'h00, 1'b0, FX_NONE, 16'h0000,
				16'hFFFF), 1'b0, '0);
		// semitone out of range, start position past the period
		queue_item(mk_item(ACT_NOTE_ON, 8'h0F, 8'h7F, 8'h0F, 1'b0, FX_NONE, 16'h0000, 16'h0000),
			1'b1, '0);
		queue_item(mk_item(ACT_EFFECT, 8'h00, 8'h00, 8'h00, 1'b1, FX_RETRIG_FINE, 16'h00F1,
			16'h0000), 1'b1, '0);
		queue_item(mk_item(ACT_ADVANCE, 8'h00, 8'h00, 8'h00, 1'b0, FX_NONE, 16'h0000, 16'h0000),
			1'b0, '0);
		queue_item(mk_item(ACT_EFFECT, 8'h00, 8'h00, 8'h00, 1'b0, FX_REWIND, 16'h0000, 16'h0000),
			1'b1, '0);
		// large positive offset clamps at the top note
		queue_item(mk_item(ACT_EFFECT, 8'h00, 8'h00, 8'h00, 1'b1, FX_ARP2, 16'h0C7F, 16'h0000),
			1'b1, '0);
		queue_item(mk_item(ACT_ADVANCE, 8'h00, 8'h00, 8'h00, 1'b0, FX_NONE, 16'h0000, 16'hFFFF),
			1'b0, '0);
		// fine retrigger with count zero disables the retrigger
		queue_item(mk_item(ACT_EFFECT, 8'h00, 8'h00, 8'h00, 1'b1, FX_RETRIG_FINE, 16'h0000,
			16'h0000), 1'b1, '0);
		queue_item(mk_item(ACT_ADVANCE, 8'h00, 8'h00, 8'h00, 1'b0, FX_NONE, 16'h0000, 16'd1234),
			1'b1, {16'd1234, 25'd0});
		play_queue();

		// random phases, tick length changed only while idle
		foreach (tick_plan[i]) begin
			set_tick(16'(tick_plan[i]));
			build_phase(PHASE_ITEMS);
			play_queue();
		end

		wait_drain();
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rtarp_pkg.sv
hw/rtl/rtarp_fifo.sv
hw/rtl/rtarp_front.sv
hw/rtl/rtarp_back.sv
hw/rtl/retrigger_arpeggio_scheduler.sv
hw/rtl/rtarp_checker.sv
sim/tb_top.sv
